>>> hdl/dtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtl_pkg;

  // field widths of the item and result channels
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned STR_W   = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned USED_W  = 5;
  localparam int unsigned OP_W    = 2;

  // default table depth
  localparam int unsigned DEPTH_DEF = 16;

  // occurrence count saturation value
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // one stored table entry
  typedef struct packed {
    logic        [ADDR_W-1:0] addr;
    logic signed [STR_W-1:0]  strength;
    logic        [CNT_W-1:0]  count;
  } entry_t;

  // one result item
  typedef struct packed {
    logic                     hit;
    logic                     evicted;
    logic        [IDX_W-1:0]  entry_index;
    logic                     entry_valid;
    logic        [ADDR_W-1:0] address;
    logic signed [STR_W-1:0]  strength;
    logic        [CNT_W-1:0]  count;
    logic        [USED_W-1:0] entries_used;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/dtl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtl_in_if;
  import dtl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   opcode;
  logic        [ADDR_W-1:0] device_address;
  logic signed [STR_W-1:0]  signal_strength;
  logic        [IDX_W-1:0]  read_index;

  modport source (
    output valid, opcode, device_address, signal_strength, read_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, device_address, signal_strength, read_index,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/dtl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtl_out_if;
  import dtl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic                     evicted;
  logic        [IDX_W-1:0]  entry_index;
  logic                     entry_valid;
  logic        [ADDR_W-1:0] address_out;
  logic signed [STR_W-1:0]  strength_out;
  logic        [CNT_W-1:0]  occurrence_count;
  logic        [USED_W-1:0] entries_used;

  modport source (
    output valid, hit, evicted, entry_index, entry_valid, address_out,
           strength_out, occurrence_count, entries_used,
    input  ready
  );

  modport sink (
    input  valid, hit, evicted, entry_index, entry_valid, address_out,
           strength_out, occurrence_count, entries_used,
    output ready
  );

endinterface

`default_nettype wire

>>> hdl/device_table_lfu_update.sv
// update: the filled entries are walked one per cycle through the registered read port;
//   the entry is then written back and the result loaded into the output register
// read uses the registered read port, clear does not; one item in flight at a time
// next input transfer is taken in the cycle after the result is loaded;
//   an untaken result holds the sequencer
// reset clears the fill level and all control state; table memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module device_table_lfu_update #(
  parameter int unsigned DEPTH = dtl_pkg::DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dtl_in_if.sink    in_i,
  dtl_out_if.source out_o
);
  import dtl_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_READ  = 6'b000100,
    S_RWAIT = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  op_e                       op_q, op_d;
  logic        [ADDR_W-1:0]  addr_q, addr_d;
  logic signed [STR_W-1:0]   str_q, str_d;
  logic        [IDX_W-1:0]   ridx_q, ridx_d;
  logic        [CW-1:0]      fill_q, fill_d;
  logic        [CW-1:0]      issue_q, issue_d;
  logic                      cmp_vld_q, cmp_vld_d;
  logic        [IW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                      found_q, found_d;
  logic        [IW-1:0]      fidx_q, fidx_d;
  logic        [CNT_W-1:0]   fcnt_q, fcnt_d;
  logic        [CNT_W-1:0]   min_q, min_d;
  logic        [IW-1:0]      minidx_q, minidx_d;
  res_t                      res_q, res_d;
  res_t                      out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  // table memory, one write and one registered read port
  entry_t                    mem_q [DEPTH];
  entry_t                    rdata_q;
  logic                      mem_we;
  logic        [IW-1:0]      wr_idx;
  entry_t                    wr_data;
  logic                      rd_en;
  logic        [IW-1:0]      rd_addr;

  logic                      full;
  logic        [CNT_W-1:0]   new_cnt;

  assign full    = (fill_q == FULL);
  assign new_cnt = (fcnt_q == COUNT_MAX) ? fcnt_q : fcnt_q + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    str_d       = str_q;
    ridx_d      = ridx_q;
    fill_d      = fill_q;
    issue_d     = issue_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    fcnt_d      = fcnt_q;
    min_d       = min_q;
    minidx_d    = minidx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we      = 1'b0;
    wr_idx      = fidx_q;
    wr_data     = '{addr: addr_q, strength: str_q, count: new_cnt};
    rd_en       = 1'b0;
    rd_addr     = IW'(issue_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d   = op_e'(in_i.opcode);
          addr_d = in_i.device_address;
          str_d  = in_i.signal_strength;
          ridx_d = in_i.read_index;
          unique case (op_e'(in_i.opcode))
            OP_UPDATE: begin
              issue_d   = '0;
              cmp_vld_d = 1'b0;
              found_d   = 1'b0;
              state_d   = S_SCAN;
            end
            OP_READ: begin
              state_d = S_READ;
            end
            OP_CLEAR: begin
              fill_d  = '0;
              res_d   = '0;
              state_d = S_OUT;
            end
            default: begin
              res_d              = '0;
              res_d.entries_used = USED_W'(fill_q);
              state_d            = S_OUT;
            end
          endcase
        end
      end

      // walk filled entries: first address match and lowest-index minimum count
      S_SCAN: begin
        if (issue_q != fill_q) begin
          rd_en     = 1'b1;
          issue_d   = issue_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = IW'(issue_q);
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (!found_q && rdata_q.addr == addr_q) begin
            found_d = 1'b1;
            fidx_d  = cmp_idx_q;
            fcnt_d  = rdata_q.count;
          end
          if (cmp_idx_q == '0 || rdata_q.count < min_q) begin
            min_d    = rdata_q.count;
            minidx_d = cmp_idx_q;
          end
        end
        if (issue_q == fill_q && !cmp_vld_q) begin
          state_d = S_WRITE;
        end
      end

      // write back the hit, the new device or the replaced entry
      S_WRITE: begin
        mem_we = 1'b1;
        if (found_q) begin
          wr_idx  = fidx_q;
          wr_data = '{addr: addr_q, strength: str_q, count: new_cnt};
        end else begin
          wr_idx  = full ? minidx_q : IW'(fill_q);
          wr_data = '{addr: addr_q, strength: str_q, count: CNT_W'(1)};
          if (!full) begin
            fill_d = fill_q + CW'(1);
          end
        end
        res_d.hit          = found_q;
        res_d.evicted      = !found_q && full;
        res_d.entry_index  = IDX_W'(wr_idx);
        res_d.entry_valid  = 1'b1;
        res_d.address      = wr_data.addr;
        res_d.strength     = wr_data.strength;
        res_d.count        = wr_data.count;
        res_d.entries_used = USED_W'(fill_d);
        state_d            = S_OUT;
      end

      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = IW'(ridx_q);
        state_d = S_RWAIT;
      end

      // entry is returned only when it lies below the fill level
      S_RWAIT: begin
        res_d              = '0;
        res_d.entry_index  = ridx_q;
        res_d.entries_used = USED_W'(fill_q);
        if (32'(ridx_q) < 32'(fill_q)) begin
          res_d.entry_valid = 1'b1;
          res_d.address     = rdata_q.addr;
          res_d.strength    = rdata_q.strength;
          res_d.count       = rdata_q.count;
        end
        state_d = S_OUT;
      end

      // load the output register once the previous result has been taken
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NOP;
      fill_q      <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      fill_q      <= fill_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    str_q     <= str_d;
    ridx_q    <= ridx_d;
    cmp_idx_q <= cmp_idx_d;
    fidx_q    <= fidx_d;
    fcnt_q    <= fcnt_d;
    min_q     <= min_d;
    minidx_q  <= minidx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // channel ports
  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.hit              = out_q.hit;
  assign out_o.evicted          = out_q.evicted;
  assign out_o.entry_index      = out_q.entry_index;
  assign out_o.entry_valid      = out_q.entry_valid;
  assign out_o.address_out      = out_q.address;
  assign out_o.strength_out     = out_q.strength;
  assign out_o.occurrence_count = out_q.count;
  assign out_o.entries_used     = out_q.entries_used;

endmodule

`default_nettype wire
